@@ rtl/ryuv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB to YUV 4:2:0 converter package
// Shared constants, colour coefficients and types of the converter.
// ----------------------------------------------------------------------------
package ryuv_pkg;

	localparam int unsigned MAX_LINE_PAIRS = 1024;
	localparam int unsigned MAX_ROW_PAIRS  = 1024;

	localparam int unsigned CFG_W   = 11;
	localparam int unsigned LINE_AW = $clog2(MAX_LINE_PAIRS);
	localparam int unsigned ROW_AW  = $clog2(MAX_ROW_PAIRS);
	localparam int unsigned ROW_W   = ROW_AW + 1;
	localparam int unsigned PROD_W  = 23;
	localparam int unsigned SUM_W   = 24;

	localparam logic [13:0] Y_R = 14'd9796;
	localparam logic [14:0] Y_G = 15'd19235;
	localparam logic [11:0] Y_B = 12'd3736;
	localparam logic [12:0] U_R = 13'd4784;
	localparam logic [13:0] U_G = 14'd9437;
	localparam logic [13:0] U_B = 14'd14221;
	localparam logic [14:0] V_R = 15'd20218;
	localparam logic [14:0] V_G = 15'd16941;
	localparam logic [11:0] V_B = 12'd3277;

	localparam logic [CFG_W-1:0] WIDTH_PAIRS_RESET  = 11'd320;
	localparam logic [CFG_W-1:0] HEIGHT_PAIRS_RESET = 11'd240;

	localparam logic [7:0] CHROMA_BIAS = 8'd32;

	typedef enum logic [0:0] {
		REG_WIDTH_PAIRS  = 1'b0,
		REG_HEIGHT_PAIRS = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic               second;
		logic               odd_row;
		logic               frame_end;
		logic [LINE_AW-1:0] column;
	} pix_ctl_t;

endpackage

@@ rtl/ryuv_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Simple dual-port RAM
// One write port and one read port with a registered read and read enable.
// ----------------------------------------------------------------------------
module ryuv_ram #(
	parameter int unsigned WIDTH = 16,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

@@ rtl/rgb24_to_yuv420p_converter.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// RGB24 to YUV 4:2:0 planar converter
// Converts a raster stream of pixels to luma per pixel and chroma per block.
// ----------------------------------------------------------------------------
// Each input word carries one pixel as blue, green and red bytes in raster
// order. Each pixel gives exactly one output word holding its luma; on the
// second pixel of every pair in an odd row the word also carries the U and V
// of the completed 2x2 block, and frame_end marks the last pixel of a frame.
// Partial chroma sums of even rows wait in a 1024-entry line memory, read
// when the matching pixel is accepted and written back when the even-row
// pixel leaves the arithmetic stage.
// The pipeline has two register stages, the arithmetic stage and then the
// output register. While out_ready is high the pipeline takes one pixel
// every cycle; the line memory has one read and one write port, so the
// read of an odd-row pixel and the write of an even-row pixel never contend.
// When the receiver holds out_ready low the output register and the
// arithmetic stage fill, then in_ready falls; nothing is lost.
// The configuration channel is always ready and should only be written while
// the block is idle. Reset sets 320 by 240 pixel pairs, clears the counters
// and empties the pipeline; the line memory needs no clearing.
// ----------------------------------------------------------------------------
module rgb24_to_yuv420p_converter (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  ryuv_pkg::cfg_reg_t          cfg_index,
	input  logic [ryuv_pkg::CFG_W-1:0]  cfg_data,
	input  logic                        in_valid,
	output logic                        in_ready,
	input  logic [7:0]                  blue,
	input  logic [7:0]                  green,
	input  logic [7:0]                  red,
	output logic                        out_valid,
	input  logic                        out_ready,
	output logic [7:0]                  luma,
	output logic                        chroma_valid,
	output logic [7:0]                  chroma_u,
	output logic [7:0]                  chroma_v,
	output logic                        frame_end
);

	import ryuv_pkg::*;

	logic [CFG_W-1:0]   width_pairs_q;
	logic [CFG_W-1:0]   height_pairs_q;
	logic               pair_phase_q;
	logic [LINE_AW-1:0] column_pair_count_q;
	logic [ROW_W-1:0]   row_count_q;
	logic [7:0]         pending_u_q;
	logic [7:0]         pending_v_q;

	logic              accept;
	logic              s1_move;
	logic [31:0]       wp_full;
	logic [31:0]       hp_full;
	logic [LINE_AW:0]  wp;
	logic [ROW_W:0]    hp2;
	logic              row_end;
	logic              frm_end;
	pix_ctl_t          ctl_next;

	logic              valid_s1;
	pix_ctl_t          ctl_s1;
	logic [PROD_W-1:0] y_r_s1, y_g_s1, y_b_s1;
	logic [PROD_W-1:0] u_r_s1, u_g_s1, u_b_s1;
	logic [PROD_W-1:0] v_r_s1, v_g_s1, v_b_s1;

	logic [SUM_W-2:0]        y_sum;
	logic signed [SUM_W-1:0] u_sum;
	logic signed [SUM_W-1:0] v_sum;
	logic [7:0]              tu, tv, su, sv;

	logic                ram_we;
	logic                ram_re;
	logic [15:0]         ram_rdata;

	logic                out_valid_q;
	logic [7:0]          luma_q, chroma_u_q, chroma_v_q;
	logic                chroma_valid_q, frame_end_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_pairs_q  <= WIDTH_PAIRS_RESET;
			height_pairs_q <= HEIGHT_PAIRS_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_WIDTH_PAIRS:  width_pairs_q  <= cfg_data;
				REG_HEIGHT_PAIRS: height_pairs_q <= cfg_data;
				default:          ;
			endcase
		end
	end

	assign s1_move  = valid_s1 && (!out_valid_q || out_ready);
	assign in_ready = !valid_s1 || s1_move;
	assign accept   = in_valid && in_ready;

	always_comb begin
		wp_full = 32'(width_pairs_q);
		if (width_pairs_q == '0) begin
			wp_full = 32'd1;
		end else if (wp_full > MAX_LINE_PAIRS) begin
			wp_full = MAX_LINE_PAIRS;
		end
		hp_full = 32'(height_pairs_q);
		if (height_pairs_q == '0) begin
			hp_full = 32'd1;
		end else if (hp_full > MAX_ROW_PAIRS) begin
			hp_full = MAX_ROW_PAIRS;
		end
		wp  = (LINE_AW + 1)'(wp_full);
		hp2 = (ROW_W + 1)'(hp_full << 1);
		row_end = ((LINE_AW + 1)'(column_pair_count_q) + 1'b1) >= wp;
		frm_end = row_end && (((ROW_W + 1)'(row_count_q) + 1'b1) >= hp2);
		ctl_next.second    = pair_phase_q;
		ctl_next.odd_row   = row_count_q[0];
		ctl_next.frame_end = pair_phase_q && frm_end;
		ctl_next.column    = column_pair_count_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pair_phase_q        <= 1'b0;
			column_pair_count_q <= '0;
			row_count_q         <= '0;
		end else if (accept) begin
			pair_phase_q <= !pair_phase_q;
			if (pair_phase_q) begin
				if (row_end) begin
					column_pair_count_q <= '0;
					if (frm_end) begin
						row_count_q <= '0;
					end else begin
						row_count_q <= row_count_q + 1'b1;
					end
				end else begin
					column_pair_count_q <= column_pair_count_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1 <= ctl_next;
			y_r_s1 <= PROD_W'(red) * PROD_W'(Y_R);
			y_g_s1 <= PROD_W'(green) * PROD_W'(Y_G);
			y_b_s1 <= PROD_W'(blue) * PROD_W'(Y_B);
			u_r_s1 <= PROD_W'(red) * PROD_W'(U_R);
			u_g_s1 <= PROD_W'(green) * PROD_W'(U_G);
			u_b_s1 <= PROD_W'(blue) * PROD_W'(U_B);
			v_r_s1 <= PROD_W'(red) * PROD_W'(V_R);
			v_g_s1 <= PROD_W'(green) * PROD_W'(V_G);
			v_b_s1 <= PROD_W'(blue) * PROD_W'(V_B);
		end
	end

	always_comb begin
		y_sum = (SUM_W - 1)'(y_r_s1) + (SUM_W - 1)'(y_g_s1) + (SUM_W - 1)'(y_b_s1);
		u_sum = $signed(SUM_W'(u_b_s1)) - $signed(SUM_W'(u_r_s1))
			- $signed(SUM_W'(u_g_s1));
		v_sum = $signed(SUM_W'(v_r_s1)) - $signed(SUM_W'(v_g_s1))
			- $signed(SUM_W'(v_b_s1));
		tu = 8'(u_sum >>> 17) + CHROMA_BIAS;
		tv = 8'(v_sum >>> 17) + CHROMA_BIAS;
		su = pending_u_q + tu;
		sv = pending_v_q + tv;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_u_q <= '0;
			pending_v_q <= '0;
		end else if (s1_move && !ctl_s1.second) begin
			pending_u_q <= tu;
			pending_v_q <= tv;
		end
	end

	assign ram_re = accept && pair_phase_q && row_count_q[0];
	assign ram_we = s1_move && ctl_s1.second && !ctl_s1.odd_row;

	ryuv_ram #(
		.WIDTH (16),
		.DEPTH (MAX_LINE_PAIRS)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ctl_s1.column),
		.wdata ({sv, su}),
		.re    (ram_re),
		.raddr (column_pair_count_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			luma_q         <= 8'(y_sum >> 15);
			chroma_valid_q <= ctl_s1.second && ctl_s1.odd_row;
			frame_end_q    <= ctl_s1.frame_end;
			if (ctl_s1.second && ctl_s1.odd_row) begin
				chroma_u_q <= su + ram_rdata[7:0];
				chroma_v_q <= sv + ram_rdata[15:8];
			end else begin
				chroma_u_q <= '0;
				chroma_v_q <= '0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign luma         = luma_q;
	assign chroma_valid = chroma_valid_q;
	assign chroma_u     = chroma_u_q;
	assign chroma_v     = chroma_v_q;
	assign frame_end    = frame_end_q;

`ifndef SYNTHESIS
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we && ram_re |-> ctl_s1.column != column_pair_count_q)
		else $error("Line store read and write hit the same entry.");

	a_read_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !s1_move |-> !ram_re)
		else $error("Line store read issued while the arithmetic stage is stalled.");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && pair_phase_q && row_end |=> column_pair_count_q == '0)
		else $error("Column count did not wrap at the end of a row.");

	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		accept && ctl_next.frame_end |=> row_count_q == '0 && !pair_phase_q)
		else $error("Counters did not return to zero at the end of a frame.");

	a_chroma_second: assert property (@(posedge clk) disable iff (!arst_n)
		s1_move && !ctl_s1.second |=> !chroma_valid_q && !frame_end_q)
		else $error("Chroma or frame end flagged on the first pixel of a pair.");
`endif

endmodule
